// ===== rtl/pathnorm_pkg.sv =====
`default_nettype none

package pathnorm_pkg;

    // default sizes of the component stack, of a name and of the emitted run
    localparam int DEF_MAX_DEPTH = 32;
    localparam int DEF_MAX_NAME  = 64;
    localparam int DEF_MAX_PATH  = 64;

    // entries of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // command field widths, sized for the largest legal configuration
    localparam int SLOT_W  = 6;
    localparam int DEPTH_W = 7;
    localparam int NAME_W  = 7;

    // characters with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // one request from the front to the back
    typedef struct packed {
        logic               emit;
        logic [DEPTH_W-1:0] emit_depth;
        logic               len_we;
        logic [SLOT_W-1:0]  len_slot;
        logic [NAME_W-1:0]  len_data;
        logic               store_we;
        logic [SLOT_W-1:0]  store_slot;
        logic [NAME_W-1:0]  store_idx;
        logic [7:0]         store_data;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pathnorm_front.sv =====
`default_nettype none

module pathnorm_front #(
    parameter int MAX_DEPTH = 32,
    parameter int MAX_NAME  = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          in_ch,
    input  wire logic                in_from_cwd,
    output logic                     cmd_valid,
    input  wire logic                cmd_ready,
    output pathnorm_pkg::cmd_t       cmd
);
    import pathnorm_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int SW = $clog2(MAX_DEPTH);
    localparam int LW = $clog2(MAX_NAME);

    // scan state plus the memory writes that one character causes
    typedef struct packed {
        logic [DW-1:0] d;
        logic [LW-1:0] len;
        logic          dots;
        logic          fz;
        logic          ps;
        logic          lw;
        logic [SW-1:0] lslot;
        logic [LW-1:0] ldata;
        logic          sw;
        logic [SW-1:0] sslot;
        logic [LW-1:0] sidx;
        logic [7:0]    sdata;
    } fst_t;

    logic [DW-1:0] depth_reg;
    logic [LW-1:0] cur_len_reg;
    logic          all_dots_reg;
    logic          frozen_reg;
    logic          path_started_reg;

    fst_t          st_next;
    logic          emit;
    logic          accept;
    logic          start_slash;
    logic          is_sep;
    logic          is_nul;

    // end of a component: skip an empty one; in the path drop a dot, pop on dot-dot; else push, freezing when full
    function automatic fst_t close_fn(input fst_t s, input logic in_path);
        fst_t r;
        r = s;
        if (s.len == '0) begin
            r.dots = 1'b1;
        end
        else begin
            if (in_path && s.dots && s.len <= LW'(2)) begin
                if (s.len == LW'(2) && s.d != '0) begin
                    r.d = s.d - 1'b1;
                end
            end
            else if (s.d < DW'(MAX_DEPTH)) begin
                r.lw    = 1'b1;
                r.lslot = SW'(s.d);
                r.ldata = s.len;
                r.d     = s.d + 1'b1;
                if (r.d >= DW'(MAX_DEPTH)) begin
                    r.fz = 1'b1;
                end
            end
            else begin
                r.fz = 1'b1;
            end
            r.len  = '0;
            r.dots = 1'b1;
        end
        return r;
    endfunction

    // ordinary name character, splitting an overlong name first
    function automatic fst_t take_fn(input fst_t s, input logic [7:0] c,
                                     input logic in_path);
        fst_t r;
        r = s;
        if (s.len >= LW'(MAX_NAME - 1)) begin
            r = close_fn(r, in_path);
        end
        if (!r.fz) begin
            if (r.d < DW'(MAX_DEPTH)) begin
                r.sw    = 1'b1;
                r.sslot = SW'(r.d);
                r.sidx  = r.len;
                r.sdata = c;
            end
            if (c != CH_DOT) begin
                r.dots = 1'b0;
            end
            r.len = r.len + 1'b1;
        end
        return r;
    endfunction

    assign accept   = in_valid && cmd_ready;
    assign in_ready = cmd_ready;
    assign is_sep   = (in_ch == CH_SLASH);
    assign is_nul   = (in_ch == CH_NUL);

    // classify the character and work out the stack update
    always_comb
    begin
        st_next       = '0;
        st_next.d     = depth_reg;
        st_next.len   = cur_len_reg;
        st_next.dots  = all_dots_reg;
        st_next.fz    = frozen_reg;
        st_next.ps    = path_started_reg;
        emit          = 1'b0;
        start_slash   = 1'b0;
        if (in_from_cwd) begin
            if (!st_next.ps && !st_next.fz) begin
                if (is_sep || is_nul) begin
                    st_next = close_fn(st_next, 1'b0);
                end
                else begin
                    st_next = take_fn(st_next, in_ch, 1'b0);
                end
            end
        end
        else begin
            if (!st_next.ps) begin
                if (!st_next.fz) begin
                    st_next = close_fn(st_next, 1'b0);
                end
                st_next.fz   = 1'b0;
                st_next.len  = '0;
                st_next.dots = 1'b1;
                st_next.ps   = 1'b1;
                if (is_sep) begin
                    st_next.d   = '0;
                    start_slash = 1'b1;
                end
            end
            if (!start_slash) begin
                if (is_nul) begin
                    if (!st_next.fz) begin
                        st_next = close_fn(st_next, 1'b1);
                    end
                    emit = 1'b1;
                end
                else if (!st_next.fz) begin
                    if (is_sep) begin
                        st_next = close_fn(st_next, 1'b1);
                    end
                    else begin
                        st_next = take_fn(st_next, in_ch, 1'b1);
                    end
                end
            end
        end
    end

    // request to the back
    always_comb
    begin
        cmd            = '0;
        cmd.emit       = emit;
        cmd.emit_depth = DEPTH_W'(st_next.d);
        cmd.len_we     = st_next.lw;
        cmd.len_slot   = SLOT_W'(st_next.lslot);
        cmd.len_data   = NAME_W'(st_next.ldata);
        cmd.store_we   = st_next.sw;
        cmd.store_slot = SLOT_W'(st_next.sslot);
        cmd.store_idx  = NAME_W'(st_next.sidx);
        cmd.store_data = st_next.sdata;
        cmd_valid      = accept && (emit || st_next.lw || st_next.sw);
    end

    // scan state, reset after every path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            depth_reg        <= '0;
            cur_len_reg      <= '0;
            all_dots_reg     <= 1'b1;
            frozen_reg       <= 1'b0;
            path_started_reg <= 1'b0;
        end
        else if (accept) begin
            if (emit) begin
                depth_reg        <= '0;
                cur_len_reg      <= '0;
                all_dots_reg     <= 1'b1;
                frozen_reg       <= 1'b0;
                path_started_reg <= 1'b0;
            end
            else begin
                depth_reg        <= st_next.d;
                cur_len_reg      <= st_next.len;
                all_dots_reg     <= st_next.dots;
                frozen_reg       <= st_next.fz;
                path_started_reg <= st_next.ps;
            end
        end
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MAX_DEPTH))
        else $error("stack depth beyond limit");

    a_nul_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_from_cwd && is_nul) |=> (depth_reg == '0 && !path_started_reg))
        else $error("stack not reset after path end");
`endif

endmodule

`default_nettype wire

// ===== rtl/pathnorm_queue.sv =====
`default_nettype none

module pathnorm_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg < CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/pathnorm_back.sv =====
`default_nettype none

module pathnorm_back #(
    parameter int MAX_DEPTH = 32,
    parameter int MAX_NAME  = 64,
    parameter int MAX_PATH  = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire pathnorm_pkg::cmd_t cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_char,
    output logic                    out_last
);
    import pathnorm_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int SW = $clog2(MAX_DEPTH);
    localparam int LW = $clog2(MAX_NAME);
    localparam int CW = $clog2(MAX_PATH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ROOT = 6'b000010,
        S_LEN  = 6'b000100,
        S_SEP  = 6'b001000,
        S_ADDR = 6'b010000,
        S_DATA = 6'b100000
    } state_t;

    logic [7:0]    name_store   [MAX_DEPTH][MAX_NAME];
    logic [LW-1:0] name_lengths [MAX_DEPTH];

    state_t        state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [SW-1:0] k_reg, k_next;
    logic [LW-1:0] l_reg, l_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;
    logic [LW-1:0] len_rd_reg;
    logic [7:0]    store_rd_reg;

    logic          pop;
    logic          out_free;
    logic          fire;
    logic [7:0]    o_char;
    logic          o_last;
    logic          clamp;
    logic          name_end;
    logic          final_slot;

    assign cmd_ready  = (state_reg == S_IDLE);
    assign pop        = cmd_valid && cmd_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign clamp      = (cnt_reg == CW'(MAX_PATH - 2));
    assign name_end   = (l_reg == len_rd_reg - LW'(1));
    assign final_slot = (DW'(k_reg) == depth_reg - DW'(1));

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    // walk the stack: root slash, then names joined by slashes
    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        k_next     = k_reg;
        l_next     = l_reg;
        cnt_next   = cnt_reg;
        fire       = 1'b0;
        o_char     = CH_SLASH;
        o_last     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && cmd.emit) begin
                    depth_next = DW'(cmd.emit_depth);
                    k_next     = '0;
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (out_free) begin
                    fire       = 1'b1;
                    o_last     = (depth_reg == '0);
                    cnt_next   = CW'(1);
                    state_next = o_last ? S_IDLE : S_LEN;
                end
            end
            S_LEN:
            begin
                l_next     = '0;
                state_next = (k_reg != '0) ? S_SEP : S_ADDR;
            end
            S_SEP:
            begin
                if (out_free) begin
                    fire       = 1'b1;
                    o_last     = clamp;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = o_last ? S_IDLE : S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (out_free) begin
                    fire     = 1'b1;
                    o_char   = store_rd_reg;
                    o_last   = clamp || (name_end && final_slot);
                    cnt_next = cnt_reg + 1'b1;
                    if (o_last) begin
                        state_next = S_IDLE;
                    end
                    else if (name_end) begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_LEN;
                    end
                    else begin
                        l_next     = l_reg + 1'b1;
                        state_next = S_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // component memories and output payload
    always_ff @(posedge clk)
    begin
        if (pop && cmd.store_we) begin
            name_store[cmd.store_slot[SW-1:0]][cmd.store_idx[LW-1:0]] <= cmd.store_data;
        end
        if (pop && cmd.len_we) begin
            name_lengths[cmd.len_slot[SW-1:0]] <= cmd.len_data[LW-1:0];
        end
        if (state_reg == S_LEN) begin
            len_rd_reg <= name_lengths[k_reg];
        end
        if (state_reg == S_ADDR) begin
            store_rd_reg <= name_store[k_reg][l_reg];
        end
        if (fire) begin
            out_char_reg <= o_char;
            out_last_reg <= o_last;
        end
    end

    // walker control and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            k_reg         <= '0;
            l_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            k_reg     <= k_next;
            l_reg     <= l_next;
            cnt_reg   <= cnt_next;
            if (fire) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_run_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (state_reg == S_SEP || state_reg == S_DATA)) |-> cnt_reg < CW'(MAX_PATH - 1))
        else $error("run longer than path limit");
`endif

endmodule

`default_nettype wire

// ===== rtl/path_normalizer_unit.sv =====
// path normalizer: canonicalizes a unix-style path given one byte per request
// input channel s_*: tdata is the character, tuser marks a working-directory
//   character; working-directory bytes come first, then the path ending in 0
// output channel m_*: the canonical path as a run of characters, '/' first,
//   then the names joined by '/'; tlast on the final character, run clamped
//   to MAX_PATH - 1 characters
// the front scans each character combinationally and sends memory writes and
//   emit requests through a four-entry queue; non-nul characters are taken
//   one per cycle while the queue has room
// the back walks the name memories on an emit request, after any queued writes
//   ahead of it: the root slash, then for each name a length read, a separator
//   before every name but the first, and an address read and a send per character
// while the back emits, the queue fills and the input stalls once it is full
// an output stall holds the walker; the output register keeps the character
// reset clears the stack and all control state; name memories are not
//   cleared and only entries written by the current scan are read
`default_nettype none

module path_normalizer_unit #(
    parameter int MAX_DEPTH = pathnorm_pkg::DEF_MAX_DEPTH,
    parameter int MAX_NAME  = pathnorm_pkg::DEF_MAX_NAME,
    parameter int MAX_PATH  = pathnorm_pkg::DEF_MAX_PATH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // ch
    input  wire logic       s_tuser,   // from_cwd
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_char
    output logic            m_tlast
);
    import pathnorm_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic front_valid;
    logic front_ready;
    logic back_valid;
    logic back_ready;

    // character scan and stack bookkeeping
    pathnorm_front #(
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_NAME  (MAX_NAME)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_ch       (s_tdata),
        .in_from_cwd (s_tuser),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready),
        .cmd         (front_cmd)
    );

    // request queue between scan and emission
    pathnorm_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_cmd)
    );

    // name memories and path emission
    pathnorm_back #(
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_NAME  (MAX_NAME),
        .MAX_PATH  (MAX_PATH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire
